FILE: hdl/seven_segment_scan_driver_macros.svh
// assertion macros for the scan driver, all on clk with arst_n low as reset
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH

// same-cycle implication
`define SSD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hdl/ssd_pkg.sv
`default_nettype none

package ssd_pkg;

	localparam int NUM_DIGITS_DEF = 4;
	localparam int NUM_SEGMENTS   = 7;
	localparam int FONT_ENTRIES   = 128;
	localparam int CHAR_W         = 7;
	localparam int POS_W          = 2;
	localparam int CMD_W          = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int TDATA_W        = 16;

	localparam logic [3:0]  MAX_BRIGHTNESS = 4'd15;
	localparam logic [15:0] BLINK_RESET    = 16'd500;
	localparam logic [7:0]  DIVIDE_RESET   = 8'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK        = 3'd0,
		CMD_WRITE       = 3'd1,
		CMD_CLEAR_POS   = 3'd2,
		CMD_CLEAR_ALL   = 3'd3,
		CMD_SHIFT_LEFT  = 3'd4,
		CMD_SHIFT_RIGHT = 3'd5
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TICK_DIVIDE       = 3'd0,
		REG_DISPLAY_ENABLE    = 3'd1,
		REG_BLINK_ENABLE      = 3'd2,
		REG_BLINK_HALF_PERIOD = 3'd3,
		REG_BRIGHTNESS        = 3'd4
	} reg_idx_t;

	// what the timing unit says about the current tick
	typedef struct packed {
		logic             draw;
		logic             blank;
		logic [POS_W-1:0] pos;
	} draw_t;

	// segment patterns indexed by ascii code
	localparam logic [NUM_SEGMENTS-1:0] FONT_ROM [FONT_ENTRIES] = '{
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h77, 7'h00, 7'h4E, 7'h00, 7'h4F, 7'h47, 7'h5E,
		7'h37, 7'h06, 7'h3C, 7'h00, 7'h0E, 7'h00, 7'h00, 7'h7E, 7'h67, 7'h00, 7'h00, 7'h5B,
		7'h00, 7'h3E, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h1F, 7'h0D, 7'h3D, 7'h00, 7'h00, 7'h00, 7'h17, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h15, 7'h1D, 7'h00, 7'h73, 7'h05, 7'h00, 7'h0F, 7'h1C, 7'h00, 7'h00,
		7'h00, 7'h6E, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

endpackage

`default_nettype wire

FILE: hdl/ssd_buffer.sv
`default_nettype none

module ssd_buffer #(
	parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire ssd_pkg::cmd_t              cmd,
	input  wire logic [ssd_pkg::POS_W-1:0]  idx,
	input  wire logic [ssd_pkg::CHAR_W-1:0] ch,
	input  wire logic [ssd_pkg::POS_W-1:0]  rd_pos,
	output logic      [ssd_pkg::CHAR_W-1:0] rd_char
);

	logic [ssd_pkg::CHAR_W-1:0] buf_q [NUM_DIGITS];
	logic [ssd_pkg::CHAR_W-1:0] buf_nxt [NUM_DIGITS];

	always_comb begin
		buf_nxt = buf_q;
		case (cmd)
			ssd_pkg::CMD_WRITE: begin
				for (int i = 0; i < NUM_DIGITS; i++)
					if (idx == ssd_pkg::POS_W'(i)) buf_nxt[i] = ch;
			end
			ssd_pkg::CMD_CLEAR_POS: begin
				for (int i = 0; i < NUM_DIGITS; i++)
					if (idx == ssd_pkg::POS_W'(i)) buf_nxt[i] = '0;
			end
			ssd_pkg::CMD_CLEAR_ALL: begin
				for (int i = 0; i < NUM_DIGITS; i++)
					buf_nxt[i] = '0;
			end
			ssd_pkg::CMD_SHIFT_LEFT: begin
				for (int i = 0; i < NUM_DIGITS - 1; i++)
					buf_nxt[i] = buf_q[i+1];
				buf_nxt[NUM_DIGITS-1] = ch;
			end
			ssd_pkg::CMD_SHIFT_RIGHT: begin
				for (int i = 1; i < NUM_DIGITS; i++)
					buf_nxt[i] = buf_q[i-1];
				buf_nxt[0] = ch;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++)
				buf_q[i] <= '0;
		end else if (en) begin
			buf_q <= buf_nxt;
		end
	end

	// character under the scan position
	always_comb begin
		rd_char = '0;
		for (int i = 0; i < NUM_DIGITS; i++)
			if (rd_pos == ssd_pkg::POS_W'(i)) rd_char = buf_q[i];
	end

endmodule

`default_nettype wire

FILE: hdl/ssd_timing.sv
`default_nettype none

module ssd_timing #(
	parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           tick_go,
	input  wire logic                           cfg_we,
	input  wire logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data,
	output ssd_pkg::draw_t                      info
);

	localparam logic [ssd_pkg::POS_W-1:0] LAST_POS = ssd_pkg::POS_W'(NUM_DIGITS - 1);

	logic [7:0]  tick_divide_q;
	logic        display_enable_q;
	logic        blink_enable_q;
	logic [15:0] blink_half_q;
	logic [3:0]  brightness_q;

	logic [7:0]                divide_count_q;
	logic [ssd_pkg::POS_W-1:0] pos_q;
	logic [15:0]               blink_count_q;
	logic                      blink_off_q;
	logic [3:0]                dim_count_q;

	logic [15:0] blink_count_nxt;
	logic        blink_off_nxt;
	logic [3:0]  dim_count_nxt;
	logic        draw;
	logic        blank;

	assign draw = (divide_count_q == tick_divide_q);

	// display, then blink, then brightness; a blanking test freezes later counters
	always_comb begin
		blink_count_nxt = blink_count_q;
		blink_off_nxt   = blink_off_q;
		dim_count_nxt   = dim_count_q;
		blank           = 1'b0;
		if (!display_enable_q) begin
			blank = 1'b1;
		end else begin
			if (blink_enable_q) begin
				if (blink_count_q < blink_half_q) begin
					blink_count_nxt = blink_count_q + 16'd1;
				end else begin
					blink_count_nxt = '0;
					blink_off_nxt   = ~blink_off_q;
				end
				blank = blink_off_nxt;
			end
			if (!blank && brightness_q != ssd_pkg::MAX_BRIGHTNESS) begin
				if (dim_count_q == brightness_q) begin
					dim_count_nxt = '0;
					blank         = 1'b1;
				end else begin
					dim_count_nxt = dim_count_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_divide_q    <= ssd_pkg::DIVIDE_RESET;
			display_enable_q <= 1'b1;
			blink_enable_q   <= 1'b0;
			blink_half_q     <= ssd_pkg::BLINK_RESET;
			brightness_q     <= ssd_pkg::MAX_BRIGHTNESS;
			divide_count_q   <= '0;
			pos_q            <= '0;
			blink_count_q    <= '0;
			blink_off_q      <= 1'b0;
			dim_count_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ssd_pkg::REG_TICK_DIVIDE:       tick_divide_q    <= cfg_data[7:0];
					ssd_pkg::REG_DISPLAY_ENABLE:    display_enable_q <= cfg_data[0];
					ssd_pkg::REG_BLINK_ENABLE: begin
						blink_enable_q <= cfg_data[0];
						blink_off_q    <= 1'b0;
					end
					ssd_pkg::REG_BLINK_HALF_PERIOD: blink_half_q     <= cfg_data[15:0];
					ssd_pkg::REG_BRIGHTNESS:        brightness_q     <= cfg_data[3:0];
					default: begin
					end
				endcase
			end
			if (tick_go) begin
				if (!draw) begin
					divide_count_q <= divide_count_q + 8'd1;
				end else begin
					divide_count_q <= '0;
					pos_q          <= (pos_q >= LAST_POS) ? '0 : pos_q + 2'd1;
					blink_count_q  <= blink_count_nxt;
					blink_off_q    <= blink_off_nxt;
					dim_count_q    <= dim_count_nxt;
				end
			end
		end
	end

	assign info = '{draw: draw, blank: blank, pos: pos_q};

endmodule

`default_nettype wire

FILE: hdl/seven_segment_scan_driver.sv
// an item is registered in the input stage on entry; a retiring drawing tick's result is registered in the result stage
// throughput: one item per cycle, every command kind, while the result side keeps taking
// a result held unread holds a drawing tick in the input stage and every item behind it
// reset: arst_n low clears the character buffer, counters and scan position, and sets the registers
// reset register values: tick_divide 1, display on, blink off, half period 500, brightness 15
`default_nettype none
`include "seven_segment_scan_driver_macros.svh"

module seven_segment_scan_driver #(
	parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input items
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [ssd_pkg::TDATA_W-1:0]    s_tdata,   // digit_index[1:0], character[8:2], zero
	input  wire logic [ssd_pkg::CMD_W-1:0]      s_tuser,   // command[2:0]
	// result items
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [ssd_pkg::TDATA_W-1:0]    m_tdata,   // digit_select[1:0], segments[8:2], zero
	// register writes
	input  wire logic                           cfg_we,
	input  wire logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data
);

	// input register stage
	logic                        valid_s1;
	ssd_pkg::cmd_t               cmd_s1;
	logic [ssd_pkg::POS_W-1:0]   idx_s1;
	logic [ssd_pkg::CHAR_W-1:0]  char_s1;

	// result register stage
	logic                              valid_s2;
	logic [ssd_pkg::POS_W-1:0]         sel_s2;
	logic [ssd_pkg::NUM_SEGMENTS-1:0]  seg_s2;

	ssd_pkg::draw_t              info;
	logic [ssd_pkg::CHAR_W-1:0]  cur_char;
	logic                        is_tick;
	logic                        produce;
	logic                        advance;
	logic                        tick_go;
	logic [ssd_pkg::NUM_SEGMENTS-1:0] seg_nxt;

	// an item in s1 produces a result only if it is a tick that hits the divider
	assign is_tick = (cmd_s1 == ssd_pkg::CMD_TICK);
	assign produce = valid_s1 && is_tick && info.draw;

	// s1 retires when it needs no output slot, or the slot is free or being emptied
	assign advance = valid_s1 && (!produce || !valid_s2 || m_tready);
	assign tick_go = advance && is_tick;

	// s1 refills in the same cycle it retires
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= ssd_pkg::cmd_t'(s_tuser);
			idx_s1  <= s_tdata[1:0];
			char_s1 <= s_tdata[8:2];
		end
	end

	// character store; edits apply as their item retires
	ssd_buffer #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_buffer (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.cmd     (cmd_s1),
		.idx     (idx_s1),
		.ch      (char_s1),
		.rd_pos  (info.pos),
		.rd_char (cur_char)
	);

	// divider, scan position, blink and dimming, plus the registers
	ssd_timing #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_timing (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_go   (tick_go),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.info      (info)
	);

	// font lookup, forced dark when any blanking test fires
	assign seg_nxt = info.blank ? '0 : ssd_pkg::FONT_ROM[cur_char];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && produce) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			sel_s2 <= info.pos;
			seg_s2 <= seg_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(ssd_pkg::TDATA_W - ssd_pkg::NUM_SEGMENTS - ssd_pkg::POS_W){1'b0}},
		seg_s2, sel_s2};

	// an empty input stage always takes an item
	`SSD_ASSERT_NOW(a_s1_empty_ready, !valid_s1, s_tready)
	// a retiring drawing tick always lands in the result register
	`SSD_ASSERT_NEXT(a_draw_lands, advance && produce, valid_s2)
	// the scan never points past the fitted digits
	`SSD_ASSERT_NOW(a_pos_range, 1'b1, {1'b0, info.pos} < 3'(NUM_DIGITS))

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

// expected draws of the scan driver, worked out from a private copy of its state
class scan_scoreboard;
	typedef struct packed {
		logic [1:0] sel;
		logic [6:0] seg;
	} digit_draw_t;

	// register copies
	logic [7:0]  tick_divide;
	logic        disp_enable;
	logic        blink_on;
	logic [15:0] half_period;
	logic [3:0]  brightness;
	// datapath copies
	logic [6:0]  chars [4];
	logic [7:0]  divide_count;
	logic [1:0]  scan_pos;
	logic [15:0] blink_count;
	logic        blink_off;
	logic [3:0]  dim_count;

	digit_draw_t expected_draws [$];
	int          errors;
	int          draws_checked;
	int          blank_draws;
	int          items_noted;

	function new();
		tick_divide  = 8'd1;
		disp_enable  = 1'b1;
		blink_on     = 1'b0;
		half_period  = 16'd500;
		brightness   = 4'd15;
		foreach (chars[i])
			chars[i] = 7'd0;
		divide_count = 8'd0;
		scan_pos     = 2'd0;
		blink_count  = 16'd0;
		blink_off    = 1'b0;
		dim_count    = 4'd0;
		errors        = 0;
		draws_checked = 0;
		blank_draws   = 0;
		items_noted   = 0;
	endfunction

	function logic [6:0] glyph(logic [6:0] c);
		case (c)
			7'd48:  return 7'h7E;
			7'd49:  return 7'h30;
			7'd50:  return 7'h6D;
			7'd51:  return 7'h79;
			7'd52:  return 7'h33;
			7'd53:  return 7'h5B;
			7'd54:  return 7'h5F;
			7'd55:  return 7'h70;
			7'd56:  return 7'h7F;
			7'd57:  return 7'h7B;
			7'd65:  return 7'h77;
			7'd67:  return 7'h4E;
			7'd69:  return 7'h4F;
			7'd70:  return 7'h47;
			7'd71:  return 7'h5E;
			7'd72:  return 7'h37;
			7'd73:  return 7'h06;
			7'd74:  return 7'h3C;
			7'd76:  return 7'h0E;
			7'd79:  return 7'h7E;
			7'd80:  return 7'h67;
			7'd83:  return 7'h5B;
			7'd85:  return 7'h3E;
			7'd98:  return 7'h1F;
			7'd99:  return 7'h0D;
			7'd100: return 7'h3D;
			7'd104: return 7'h17;
			7'd110: return 7'h15;
			7'd111: return 7'h1D;
			7'd113: return 7'h73;
			7'd114: return 7'h05;
			7'd116: return 7'h0F;
			7'd117: return 7'h1C;
			7'd121: return 7'h6E;
			default: return 7'h00;
		endcase
	endfunction

	function void write_reg(ssd_pkg::reg_idx_t r, logic [15:0] v);
		case (r)
			ssd_pkg::REG_TICK_DIVIDE:       tick_divide = v[7:0];
			ssd_pkg::REG_DISPLAY_ENABLE:    disp_enable = v[0];
			ssd_pkg::REG_BLINK_ENABLE: begin
				blink_on  = v[0];
				blink_off = 1'b0;
			end
			ssd_pkg::REG_BLINK_HALF_PERIOD: half_period = v;
			ssd_pkg::REG_BRIGHTNESS:        brightness  = v[3:0];
			default: ;
		endcase
	endfunction

	// blink counter moves only when the display test passed
	function bit blink_passes();
		if (!blink_on)
			return 1'b1;
		if (blink_count < half_period) begin
			blink_count = blink_count + 16'd1;
		end else begin
			blink_count = 16'd0;
			blink_off   = ~blink_off;
		end
		return !blink_off;
	endfunction

	function bit dim_passes();
		if (brightness == 4'd15)
			return 1'b1;
		if (dim_count == brightness) begin
			dim_count = 4'd0;
			return 1'b0;
		end
		dim_count = dim_count + 4'd1;
		return 1'b1;
	endfunction

	function void note_command(logic [2:0] cmd, logic [1:0] idx, logic [6:0] ch);
		digit_draw_t d;
		logic [6:0]  carry;
		logic [6:0]  t;
		bit          shown;
		items_noted++;
		case (cmd)
			ssd_pkg::CMD_TICK: begin
				if (divide_count != tick_divide) begin
					divide_count = divide_count + 8'd1;
				end else begin
					divide_count = 8'd0;
					shown = disp_enable;
					if (shown)
						shown = blink_passes();
					if (shown)
						shown = dim_passes();
					d.sel = scan_pos;
					d.seg = shown ? glyph(chars[scan_pos]) : 7'd0;
					if (!shown)
						blank_draws++;
					expected_draws.push_back(d);
					scan_pos = scan_pos + 2'd1;
				end
			end
			ssd_pkg::CMD_WRITE:     chars[idx] = ch;
			ssd_pkg::CMD_CLEAR_POS: chars[idx] = 7'd0;
			ssd_pkg::CMD_CLEAR_ALL: begin
				foreach (chars[i])
					chars[i] = 7'd0;
			end
			ssd_pkg::CMD_SHIFT_LEFT: begin
				carry = ch;
				for (int i = 3; i >= 0; i--) begin
					t        = chars[i];
					chars[i] = carry;
					carry    = t;
				end
			end
			ssd_pkg::CMD_SHIFT_RIGHT: begin
				carry = ch;
				for (int i = 0; i < 4; i++) begin
					t        = chars[i];
					chars[i] = carry;
					carry    = t;
				end
			end
			default: ;
		endcase
	endfunction

	function void check_draw(logic [1:0] sel, logic [6:0] seg);
		digit_draw_t want;
		if (expected_draws.size() == 0) begin
			$display("%0t: unexpected draw, actual digit %0d segments %h", $time, sel, seg);
			errors++;
			return;
		end
		want = expected_draws.pop_front();
		if (sel !== want.sel) begin
			$display("%0t: digit_select expected %0d actual %0d", $time, want.sel, sel);
			errors++;
		end
		if (seg !== want.seg) begin
			$display("%0t: segments expected %h actual %h", $time, want.seg, seg);
			errors++;
		end
		draws_checked++;
	endfunction
endclass

module tb;
	localparam int unsigned HOLD_CYCLES    = 400;  // long receiver hold-off
	localparam int unsigned WATCHDOG_LIMIT = 4000; // cycles with no item moving
	localparam int unsigned SETTLE_CYCLES  = 4;    // settling margin after the last expected draw

	// command codes the block has no use for
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [2:0] cmd;
		logic [1:0] idx;
		logic [6:0] ch;
	} scan_item_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [ssd_pkg::TDATA_W-1:0]    s_tdata;   // digit_index[1:0], character[8:2], zero
	logic [ssd_pkg::CMD_W-1:0]      s_tuser;   // command[2:0]
	logic                           m_tvalid;
	logic                           m_tready;
	logic [ssd_pkg::TDATA_W-1:0]    m_tdata;   // digit_select[1:0], segments[8:2], zero
	logic                           cfg_we;
	logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data;

	scan_scoreboard sb;
	bit             no_gaps;       // both sides run flat out
	bit             hold_off_req;  // asks the receiver for one long hold-off
	int             holds_done;
	int             phases_run;

	seven_segment_scan_driver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// every input known from time zero
	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		no_gaps      = 1'b0;
		hold_off_req = 1'b0;
		holds_done   = 0;
		phases_run   = 0;
		sb = new();
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// a few items are spare codes, tick_pct of the others are ticks, the rest edit the buffer
	function automatic scan_item_t random_item(int unsigned tick_pct);
		scan_item_t  it;
		int unsigned r;
		int unsigned k;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 99);
		it.idx = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 1) == 0)
			it.ch = 7'($urandom_range(0, 127));
		else
			it.ch = 7'($urandom_range(48, 121));
		if ($urandom_range(0, 99) < 3)
			it.cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
		else if (r < tick_pct)
			it.cmd = ssd_pkg::CMD_TICK;
		else if (k < 45)
			it.cmd = ssd_pkg::CMD_WRITE;
		else if (k < 60)
			it.cmd = ssd_pkg::CMD_CLEAR_POS;
		else if (k < 68)
			it.cmd = ssd_pkg::CMD_CLEAR_ALL;
		else if (k < 84)
			it.cmd = ssd_pkg::CMD_SHIFT_LEFT;
		else
			it.cmd = ssd_pkg::CMD_SHIFT_RIGHT;
		return it;
	endfunction

	// offer one item, called at a falling edge, returns at a falling edge
	task automatic send_item(input logic [2:0] cmd, input logic [1:0] idx, input logic [6:0] ch);
		int unsigned gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'd0, ch, idx};
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		sb.note_command(cmd, idx, ch);
		@(negedge clk);
	endtask

	// stop offering, let every expected draw arrive, then allow the pipeline to empty
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_draws.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input ssd_pkg::reg_idx_t r, input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(posedge clk);
		sb.write_reg(r, v);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// one setting of all registers, then a run of random items
	task automatic run_phase(
		input logic [7:0]  div,
		input logic        disp,
		input logic        blink,
		input logic [15:0] half,
		input logic [3:0]  bright,
		input int unsigned count,
		input int unsigned tick_pct,
		input bit          burst,
		input bit          hold,
		input bit          drain_mid
	);
		scan_item_t  it;
		int unsigned done;
		wait_drained();
		write_reg(ssd_pkg::REG_TICK_DIVIDE, 16'(div));
		write_reg(ssd_pkg::REG_DISPLAY_ENABLE, 16'(disp));
		write_reg(ssd_pkg::REG_BLINK_HALF_PERIOD, half);
		write_reg(ssd_pkg::REG_BRIGHTNESS, 16'(bright));
		write_reg(ssd_pkg::REG_BLINK_ENABLE, 16'(blink));
		no_gaps = burst;
		if (hold)
			hold_off_req = 1'b1;
		done = 0;
		while (done < count) begin
			it = random_item(tick_pct);
			send_item(it.cmd, it.idx, it.ch);
			// ignored codes do not count towards the phase
			if (it.cmd <= ssd_pkg::CMD_SHIFT_RIGHT)
				done++;
			if (drain_mid && done == count / 2)
				wait_drained();
		end
		no_gaps = 1'b0;
		phases_run++;
	endtask

	// result side: random stalls, a long hold-off on request, none in burst phases
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				holds_done++;
			end else if (stall_left != 0) begin
				stall_left--;
			end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
				m_tready <= 1'b0;
				if ($urandom_range(0, 9) < 8)
					stall_left = $urandom_range(0, 2);
				else
					stall_left = $urandom_range(8, 40);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result check at each accepted draw
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
			sb.check_draw(m_tdata[1:0], m_tdata[8:2]);
	end

	// watchdog on cycles where no item moves on either side
	initial begin : watchdog
		int unsigned idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
			    (m_tvalid === 1'b1 && m_tready === 1'b1))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		#1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part under reset settings: a draw on every second tick
		send_item(ssd_pkg::CMD_WRITE, 2'd0, 7'd48);      // glyph zero
		send_item(ssd_pkg::CMD_WRITE, 2'd1, 7'h7F);      // top code, no glyph
		send_item(ssd_pkg::CMD_WRITE, 2'd2, 7'd65);
		send_item(ssd_pkg::CMD_WRITE, 2'd3, 7'd121);
		repeat (8) send_item(ssd_pkg::CMD_TICK, 2'd0, 7'd0);
		send_item(ssd_pkg::CMD_SHIFT_LEFT, 2'd0, 7'd98);
		send_item(ssd_pkg::CMD_SHIFT_RIGHT, 2'd3, 7'd69);
		send_item(ssd_pkg::CMD_CLEAR_POS, 2'd1, 7'd0);
		// spare codes must leave the buffer alone
		send_item(CMD_SPARE_6, 2'd3, 7'h7F);
		send_item(CMD_SPARE_7, 2'd0, 7'h55);
		repeat (4) send_item(ssd_pkg::CMD_TICK, 2'd3, 7'h7F);
		send_item(ssd_pkg::CMD_CLEAR_ALL, 2'd2, 7'h2A);
		send_item(ssd_pkg::CMD_WRITE, 2'd3, 7'd0);
		send_item(ssd_pkg::CMD_WRITE, 2'd0, 7'd56);
		repeat (4) send_item(ssd_pkg::CMD_TICK, 2'd0, 7'd0);

		// divider, display, blink and brightness through their extremes
		run_phase(8'd0,   1'b1, 1'b0, 16'd500,   4'd15, 100, 60, 1'b0, 1'b0, 1'b0);
		run_phase(8'd0,   1'b1, 1'b1, 16'd0,     4'd15,  80, 60, 1'b0, 1'b0, 1'b0);
		run_phase(8'd2,   1'b1, 1'b1, 16'd3,     4'd7,   80, 70, 1'b0, 1'b0, 1'b0);
		run_phase(8'd0,   1'b0, 1'b1, 16'd2,     4'd0,   50, 60, 1'b0, 1'b0, 1'b0);
		run_phase(8'd1,   1'b1, 1'b0, 16'd65535, 4'd0,   60, 60, 1'b0, 1'b0, 1'b0);
		// slow divider leaves the count high, then a lowered divider must wrap round first
		run_phase(8'd255, 1'b1, 1'b0, 16'd500,   4'd15,  60, 90, 1'b0, 1'b0, 1'b0);
		run_phase(8'd0,   1'b1, 1'b1, 16'd1,     4'd9,  250, 85, 1'b0, 1'b0, 1'b0);
		// long hold-off fills the block, then a full drain halfway through
		run_phase(8'd3,   1'b1, 1'b1, 16'd65535, 4'd14, 150, 70, 1'b0, 1'b1, 1'b1);
		run_phase(8'd0,   1'b1, 1'b1, 16'd5,     4'd3,  100, 60, 1'b1, 1'b0, 1'b0);
		repeat (3)
			run_phase(8'($urandom_range(0, 3)), ($urandom_range(0, 3) != 0),
			          1'($urandom_range(0, 1)), 16'($urandom_range(0, 6)),
			          4'($urandom_range(0, 15)), 60, 65, 1'b0, 1'b0, 1'b0);

		wait_drained();
		repeat (10) @(posedge clk);

		$display("covered %0d items in %0d register phases, %0d long hold-offs",
		         sb.items_noted, phases_run, holds_done);
		$display("checked %0d draws, %0d of them blanked", sb.draws_checked, sb.blank_draws);
		if (sb.expected_draws.size() != 0)
			$display("%0t: %0d expected draws never arrived", $time, sb.expected_draws.size());
		if (sb.errors == 0 && sb.expected_draws.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
